// ===== rtl/escaped_frame_receiver_crc_check_top_assert.svh =====
// Assertion macros included by the receiver queue and back end
`ifndef ESCAPED_FRAME_RECEIVER_CRC_CHECK_TOP_ASSERT_SVH
`define ESCAPED_FRAME_RECEIVER_CRC_CHECK_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define EFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define EFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/efr_pkg.sv =====
package efr_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int CRC_W    = 16;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Frame size limit default
    localparam int MAX_FRAME_DEF = 256;

    // Holding line depth (CRC bytes held back)
    localparam int HOLD_DEPTH = 2;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Register reset values
    localparam logic [BYTE_W-1:0] START_RST  = 8'hFD;
    localparam logic [BYTE_W-1:0] END_RST    = 8'hFE;
    localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'hFF;
    localparam logic [CRC_W-1:0]  SEED_RST   = 16'hFFFF;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START  = 2'd0,
        CFG_END    = 2'd1,
        CFG_ESCAPE = 2'd2,
        CFG_SEED   = 2'd3
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_CRC   = 2'd1,
        ST_SHORT = 2'd2,
        ST_OVF   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STORE = 2'd1,
        OP_END   = 2'd2
    } t_op_kind;

    // One command from the front to the back
    typedef struct packed {
        t_op_kind           kind;
        logic [BYTE_W-1:0]  data;
    } t_op;

    // Push side of the queue
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_push;

    // Pop side of the queue
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_head;

    // CRC-16/CCITT, MSB first, one byte
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/efr_if.sv =====
// Received byte channel
interface efr_rx_if;
    logic                          valid;
    logic                          ready;
    logic [efr_pkg::BYTE_W-1:0]    rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel
interface efr_res_if;
    logic                          valid;
    logic                          ready;
    logic                          item_kind;
    logic [efr_pkg::BYTE_W-1:0]    payload_byte;
    logic [efr_pkg::STATUS_W-1:0]  frame_status;
    logic [efr_pkg::LEN_W-1:0]     frame_length;

    modport source (output valid, output item_kind, output payload_byte,
                    output frame_status, output frame_length, input ready);
    modport sink   (input valid, input item_kind, input payload_byte,
                    input frame_status, input frame_length, output ready);
endinterface

// Configuration write channel
interface efr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [efr_pkg::CFG_IDX_W-1:0] addr;
    logic [efr_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== rtl/escaped_frame_receiver_crc_check_top.sv =====
// A payload byte or frame report passes through the command queue and then the output
// register before it is presented. Throughput: one received byte per cycle while the queue
// is not full; the back end retires one command per cycle while its output slot is free.
// A two-entry command queue lets the input and output sides stall independently.
// Reset: i_rst_n synchronous, active low; clears frame state, queue and output valid,
// loads code registers with FD/FE/FF and the CRC seed with FFFF. No clearing pass.
module escaped_frame_receiver_crc_check_top #(
    parameter int MAX_FRAME = efr_pkg::MAX_FRAME_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    efr_rx_if.sink     i_rx,
    efr_cfg_if.sink    i_cfg,
    efr_res_if.source  o_res
);

    logic [efr_pkg::BYTE_W-1:0] r_start_code, r_end_code, r_escape_code;
    logic [efr_pkg::CRC_W-1:0]  r_crc_seed;

    efr_pkg::t_push push;
    efr_pkg::t_head head;
    logic           q_full;
    logic           pop;

    assign i_cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code  <= efr_pkg::START_RST;
            r_end_code    <= efr_pkg::END_RST;
            r_escape_code <= efr_pkg::ESCAPE_RST;
            r_crc_seed    <= efr_pkg::SEED_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (efr_pkg::t_cfg_idx'(i_cfg.addr))
                efr_pkg::CFG_START:  r_start_code  <= i_cfg.data[efr_pkg::BYTE_W-1:0];
                efr_pkg::CFG_END:    r_end_code    <= i_cfg.data[efr_pkg::BYTE_W-1:0];
                efr_pkg::CFG_ESCAPE: r_escape_code <= i_cfg.data[efr_pkg::BYTE_W-1:0];
                efr_pkg::CFG_SEED:   r_crc_seed    <= i_cfg.data[efr_pkg::CRC_W-1:0];
                default:             r_crc_seed    <= r_crc_seed;
            endcase
        end
    end

    efr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx          (i_rx),
        .i_start_code  (r_start_code),
        .i_end_code    (r_end_code),
        .i_escape_code (r_escape_code),
        .i_q_full      (q_full),
        .o_push        (push)
    );

    efr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    efr_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_crc_seed (r_crc_seed),
        .o_pop      (pop),
        .o_res      (o_res)
    );

endmodule

// ===== rtl/efr_front.sv =====
module efr_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    efr_rx_if.sink                      i_rx,
    input  logic [efr_pkg::BYTE_W-1:0]  i_start_code,
    input  logic [efr_pkg::BYTE_W-1:0]  i_end_code,
    input  logic [efr_pkg::BYTE_W-1:0]  i_escape_code,
    input  logic                        i_q_full,
    output efr_pkg::t_push              o_push
);

    logic r_in_frame, n_in_frame;
    logic r_esc, n_esc;
    logic accept;
    logic [efr_pkg::BYTE_W-1:0] c;
    logic is_code;

    assign i_rx.ready = !i_q_full;
    assign accept     = i_rx.valid && i_rx.ready;
    assign c          = i_rx.rx_byte;
    assign is_code    = (c == i_start_code) || (c == i_end_code) || (c == i_escape_code);

    // Destuff and classify the received byte into a command
    always_comb begin
        n_in_frame    = r_in_frame;
        n_esc         = r_esc;
        o_push.valid  = 1'b0;
        o_push.op.kind = efr_pkg::OP_STORE;
        o_push.op.data = c;
        if (accept) begin
            priority if (r_esc) begin
                n_esc        = 1'b0;
                o_push.valid = is_code;
            end else if (c == i_start_code) begin
                n_in_frame     = 1'b1;
                o_push.valid   = 1'b1;
                o_push.op.kind = efr_pkg::OP_START;
            end else if (!r_in_frame) begin
                n_in_frame = 1'b0;
            end else if (c == i_end_code) begin
                n_in_frame     = 1'b0;
                o_push.valid   = 1'b1;
                o_push.op.kind = efr_pkg::OP_END;
            end else if (c == i_escape_code) begin
                n_esc = 1'b1;
            end else begin
                o_push.valid = 1'b1;
            end
        end
    end

    // Hold frame and escape state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_esc      <= 1'b0;
        end else begin
            r_in_frame <= n_in_frame;
            r_esc      <= n_esc;
        end
    end

endmodule

// ===== rtl/efr_queue.sv =====
`include "escaped_frame_receiver_crc_check_top_assert.svh"

module efr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  efr_pkg::t_push  i_push,
    input  logic            i_pop,
    output logic            o_full,
    output efr_pkg::t_head  o_head
);

    efr_pkg::t_op r_mem [efr_pkg::QDEPTH];
    logic [efr_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [efr_pkg::QCNT_W-1:0] r_cnt, n_cnt;
    logic do_push, do_pop;

    assign o_full      = (r_cnt == efr_pkg::QCNT_W'(efr_pkg::QDEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.op    = r_mem[r_rd_ptr];
    assign do_push     = i_push.valid && !o_full;
    assign do_pop      = i_pop && o_head.valid;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + efr_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - efr_pkg::QCNT_W'(1);
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == efr_pkg::QPTR_W'(efr_pkg::QDEPTH - 1))
                            ? '0 : r_wr_ptr + efr_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == efr_pkg::QPTR_W'(efr_pkg::QDEPTH - 1))
                            ? '0 : r_rd_ptr + efr_pkg::QPTR_W'(1);
            end
        end
    end

    // Store commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.op;
        end
    end

endmodule

// ===== rtl/efr_back.sv =====
`include "escaped_frame_receiver_crc_check_top_assert.svh"

module efr_back #(
    parameter int MAX_FRAME = efr_pkg::MAX_FRAME_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  efr_pkg::t_head              i_head,
    input  logic [efr_pkg::CRC_W-1:0]   i_crc_seed,
    output logic                        o_pop,
    efr_res_if.source                   o_res
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_FRAME);

    logic [efr_pkg::BYTE_W-1:0] r_held [efr_pkg::HOLD_DEPTH];
    logic [1:0]                 r_held_cnt;
    logic [efr_pkg::CRC_W-1:0]  r_crc;
    logic [CNT_W-1:0]           r_count;
    logic                       r_ovf;

    logic                          r_out_valid;
    logic                          r_kind;
    logic [efr_pkg::BYTE_W-1:0]    r_byte;
    efr_pkg::t_status              r_status;
    logic [efr_pkg::LEN_W-1:0]     r_len;

    logic slot_free;
    logic full_line;
    logic emit;
    efr_pkg::t_status end_status;

    assign slot_free = !r_out_valid || o_res.ready;
    assign o_pop     = i_head.valid && slot_free;
    assign full_line = (r_held_cnt == 2'(efr_pkg::HOLD_DEPTH));

    // Popped command that presents a result
    assign emit = o_pop && ((i_head.op.kind == efr_pkg::OP_END) ||
                            (i_head.op.kind == efr_pkg::OP_STORE && full_line &&
                             r_count < MAXC));

    // Frame status at the end code
    always_comb begin
        priority if (r_ovf) begin
            end_status = efr_pkg::ST_OVF;
        end else if (!full_line) begin
            end_status = efr_pkg::ST_SHORT;
        end else if ({r_held[0], r_held[1]} == r_crc) begin
            end_status = efr_pkg::ST_OK;
        end else begin
            end_status = efr_pkg::ST_CRC;
        end
    end

    // Carry out one command per cycle while the output slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt  <= '0;
            r_crc       <= efr_pkg::SEED_RST;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                unique case (i_head.op.kind)
                    efr_pkg::OP_START: begin
                        r_held_cnt <= '0;
                        r_count    <= '0;
                        r_ovf      <= 1'b0;
                        r_crc      <= i_crc_seed;
                    end
                    efr_pkg::OP_STORE: begin
                        if (!full_line) begin
                            r_held_cnt <= r_held_cnt + 2'd1;
                        end else if (r_count < MAXC) begin
                            r_crc   <= efr_pkg::crc_byte(r_crc, r_held[0]);
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    efr_pkg::OP_END: begin
                        r_held_cnt <= '0;
                        r_count    <= '0;
                        r_ovf      <= 1'b0;
                        r_crc      <= i_crc_seed;
                    end
                    default: begin
                        r_ovf <= r_ovf;
                    end
                endcase
            end
        end
    end

    // Holding line and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.op.kind == efr_pkg::OP_STORE) begin
            if (!full_line) begin
                r_held[r_held_cnt[0]] <= i_head.op.data;
            end else begin
                r_held[0] <= r_held[1];
                r_held[1] <= i_head.op.data;
            end
        end
        if (o_pop) begin
            if (i_head.op.kind == efr_pkg::OP_END) begin
                r_kind   <= efr_pkg::KIND_REPORT;
                r_byte   <= '0;
                r_status <= end_status;
                r_len    <= efr_pkg::LEN_W'(r_count);
            end else begin
                r_kind   <= efr_pkg::KIND_PAYLOAD;
                r_byte   <= r_held[0];
                r_status <= efr_pkg::ST_OK;
                r_len    <= '0;
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.item_kind    = r_kind;
    assign o_res.payload_byte = r_byte;
    assign o_res.frame_status = r_status;
    assign o_res.frame_length = r_len;

    `EFR_ASSERT_IMP(a_held_bound, i_clk, i_rst_n, 1'b1, r_held_cnt <= 2'(efr_pkg::HOLD_DEPTH), "holding line count out of range")
    `EFR_ASSERT_IMP(a_ovf_at_max, i_clk, i_rst_n, r_ovf, r_count == MAXC, "overflow flagged below frame limit")
    `EFR_ASSERT_NEXT(a_release, i_clk, i_rst_n, o_pop && i_head.op.kind == efr_pkg::OP_STORE && full_line && r_count < MAXC, r_out_valid && r_kind == efr_pkg::KIND_PAYLOAD, "released byte not presented")

endmodule
